// ===== src/dtfc_pkg.sv =====
`default_nettype none

package dtfc_pkg;

    localparam int CP_W       = 21;
    localparam int WS_MAX_DEF = 16;

    localparam logic [CP_W-1:0] CJK_LO      = 21'h004e00;
    localparam logic [CP_W-1:0] CJK_HI      = 21'h009fff;
    localparam logic [CP_W-1:0] CJK_EXT_LO  = 21'h003400;
    localparam logic [CP_W-1:0] CJK_EXT_HI  = 21'h004dbf;
    localparam logic [CP_W-1:0] ELLIPSIS    = 21'h002026;
    localparam logic [CP_W-1:0] WSPACE_LO   = 21'h002000;
    localparam logic [CP_W-1:0] WSPACE_HI   = 21'h00200f;

    typedef enum logic [1:0] {
        LEAD_START = 2'd0,
        LEAD_HELD  = 2'd1,
        LEAD_SKIP  = 2'd2,
        LEAD_PASS  = 2'd3
    } lead_mode_t;

    // Characters that leave the leading-filler stage for one word
    typedef struct packed {
        logic [CP_W-1:0] v0;
        logic [CP_W-1:0] v1;
        logic [1:0]      n;
        logic            last;
    } lead_list_t;

    // Punctuation and body-start state after one character
    typedef struct packed {
        logic [CP_W-1:0] pchar;
        logic [1:0]      pcount;
        logic            body;
        logic            emit;
    } punct_res_t;

    function automatic logic is_cjk(input logic [CP_W-1:0] c);
        return ((c >= CJK_LO) && (c <= CJK_HI)) || ((c >= CJK_EXT_LO) && (c <= CJK_EXT_HI));
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] c);
        logic r;
        if (c < 21'h80)
            r = (c == 21'h20) || ((c >= 21'h09) && (c <= 21'h0d));
        else
            r = (c >= WSPACE_LO) && (c <= WSPACE_HI);
        return r;
    endfunction

    function automatic logic is_punct(input logic [CP_W-1:0] c);
        logic r;
        case (c)
            21'h2e, 21'h2c, 21'h21, 21'h3f, 21'h3b,
            21'h3a, 21'h28, 21'h29, 21'h22, 21'h27,
            21'h2018, 21'h2019, 21'h201c, 21'h201d,
            21'h2026, 21'h2014, 21'h2013,
            21'h3001, 21'h3002, 21'h300a, 21'h300b,
            21'hff01, 21'hff0c, 21'hff1a, 21'hff1b,
            21'hff1f, 21'hff08, 21'hff09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_punct_or_space(input logic [CP_W-1:0] c);
        return is_punct(c) || is_space(c);
    endfunction

    function automatic logic is_laugh(input logic [CP_W-1:0] c);
        return (c == 21'h54c8) || (c == 21'h563f) || (c == 21'h5475) || (c == 21'h563b);
    endfunction

    function automatic logic is_uncond_filler(input logic [CP_W-1:0] c);
        return (c == 21'h55ef) || (c == 21'h5443);
    endfunction

    function automatic logic is_cond_filler(input logic [CP_W-1:0] c);
        return (c == 21'h554a) || (c == 21'h54e6) || (c == 21'h5662) ||
               (c == 21'h5509) || (c == 21'h54ce) || (c == 21'h8bf6);
    endfunction

    // Copies a held CJK run leaves behind when it ends
    function automatic logic [1:0] run_copies(input logic [1:0] cnt, input logic [CP_W-1:0] c);
        logic [1:0] r;
        if (cnt == 2'd3)
            r = is_laugh(c) ? 2'd2 : 2'd1;
        else
            r = cnt;
        return r;
    endfunction

    // Collapse punctuation runs, then strip leading punctuation and space
    function automatic punct_res_t punct_step(input logic [CP_W-1:0] y,
                                              input logic [CP_W-1:0] pchar,
                                              input logic [1:0]      pcount,
                                              input logic            body);
        punct_res_t r;
        logic       pass;
        r.pchar  = pchar;
        r.pcount = pcount;
        r.body   = body;
        r.emit   = 1'b0;
        pass     = 1'b1;
        if (!is_punct(y)) begin
            r.pchar  = '0;
            r.pcount = 2'd0;
        end else if ((pcount != 2'd0) && (y == pchar)) begin
            if ((y == ELLIPSIS) && (pcount == 2'd1))
                r.pcount = 2'd2;
            else
                pass = 1'b0;
        end else begin
            r.pchar  = y;
            r.pcount = 2'd1;
        end
        if (pass) begin
            if (body || !is_punct_or_space(y)) begin
                r.body = 1'b1;
                r.emit = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/dtfc_ram.sv =====
`default_nettype none

module dtfc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/dtfc_lead.sv =====
`default_nettype none

module dtfc_lead (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [dtfc_pkg::CP_W-1:0]   cp,
    input  wire logic                        last,
    output dtfc_pkg::lead_list_t             list
);

    dtfc_pkg::lead_mode_t        mode_reg, mode_next;
    logic [dtfc_pkg::CP_W-1:0]   held_reg, held_next;

    // Hold the leading-filler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= dtfc_pkg::LEAD_START;
            held_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    // Decide which characters go on to the run stage
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        list.v0   = cp;
        list.v1   = cp;
        list.n    = 2'd0;
        list.last = last;
        case (mode_reg)
            dtfc_pkg::LEAD_START:
            begin
                if (dtfc_pkg::is_uncond_filler(cp)) begin
                    mode_next = dtfc_pkg::LEAD_SKIP;
                end else if (dtfc_pkg::is_cond_filler(cp)) begin
                    mode_next = dtfc_pkg::LEAD_HELD;
                    held_next = cp;
                end else begin
                    mode_next = dtfc_pkg::LEAD_PASS;
                    list.n    = 2'd1;
                end
            end
            dtfc_pkg::LEAD_HELD:
            begin
                held_next = '0;
                if (dtfc_pkg::is_punct_or_space(cp)) begin
                    mode_next = dtfc_pkg::LEAD_SKIP;
                end else begin
                    mode_next = dtfc_pkg::LEAD_PASS;
                    list.v0   = held_reg;
                    list.n    = 2'd2;
                end
            end
            dtfc_pkg::LEAD_SKIP:
            begin
                if (!dtfc_pkg::is_punct_or_space(cp)) begin
                    mode_next = dtfc_pkg::LEAD_PASS;
                    list.n    = 2'd1;
                end
            end
            default:
            begin
                list.n = 2'd1;
            end
        endcase
        // A conditional filler alone in its message is kept; every message restarts
        if (last) begin
            if (mode_next == dtfc_pkg::LEAD_HELD)
                list.n = 2'd1;
            mode_next = dtfc_pkg::LEAD_START;
            held_next = '0;
        end
    end

endmodule

`default_nettype wire

// ===== src/dictation_text_filler_cleanup_unit.sv =====
// Channel   Dir  Signals                      Word
// s_axis    in   tvalid tready tdata tlast    codepoint; tlast = last of message
// m_axis    out  tvalid tready tdata tuser    out_codepoint; tuser = has_char;
//                tlast                        tlast = end_of_message
//
// A CJK run that ends with two copies, a held filler let through, or a
// character after a flushed run makes a word take longer than the rest.
// A held space run is released one space per cycle from the space RAM,
// unless the output stalls, after the step that starts it; message end emits a marker.
// Reset (rst_n, asynchronous) empties all held state; nothing needs clearing.
// A stalled output register stops the engine; input is taken while the
// current word finishes.
`default_nettype none

module dictation_text_filler_cleanup_unit #(
    parameter int WS_MAX = dtfc_pkg::WS_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [20:0] codepoint, [23:21] zero
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [20:0] out_codepoint, [23:21] zero
    output logic             m_axis_tuser,   // [0] has_char
    output logic             m_axis_tlast
);

    localparam int CPW = dtfc_pkg::CP_W;
    localparam int CW  = $clog2(WS_MAX + 1);
    localparam int AW  = (WS_MAX > 1) ? $clog2(WS_MAX) : 1;

    dtfc_pkg::lead_list_t lead;
    dtfc_pkg::punct_res_t pr;

    logic            accept, adv, work_done, remaining;
    logic [CPW-1:0]  x;
    logic            x_ok, flush_now;
    logic [1:0]      cur_left;

    logic            w_valid_reg, w_valid_next;
    logic [CPW-1:0]  w_v0_reg, w_v0_next, w_v1_reg, w_v1_next;
    logic [1:0]      w_n_reg, w_n_next, w_pos_reg, w_pos_next;
    logic            w_last_reg, w_last_next;

    logic [CPW-1:0]  run_char_reg, run_char_next;
    logic [1:0]      run_count_reg, run_count_next;
    logic            prev_cjk_reg, prev_cjk_next;
    logic [CW-1:0]   space_count_reg, space_count_next;
    logic [CPW-1:0]  punct_char_reg, punct_char_next;
    logic [1:0]      punct_count_reg, punct_count_next;
    logic            body_reg, body_next;
    logic [1:0]      f_left_reg, f_left_next;
    logic            rel_active_reg, rel_active_next;
    logic [AW-1:0]   rel_idx_reg, rel_idx_next;
    logic            y3_pend_reg, y3_pend_next;
    logic [CPW-1:0]  y3_reg, y3_next;

    logic            out_valid_reg, out_valid_next;
    logic [CPW-1:0]  out_cp_reg, out_cp_next;
    logic            out_has_reg, out_has_next, out_eom_reg, out_eom_next;

    logic            emit;
    logic [CPW-1:0]  e_cp;
    logic            e_has, e_eom;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [CPW-1:0]  rd_data;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign adv    = !out_valid_reg || m_axis_tready;

    dtfc_lead u_lead (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cp     (s_axis_tdata[CPW-1:0]),
        .last   (s_axis_tlast),
        .list   (lead)
    );

    dtfc_ram #(
        .WIDTH (CPW),
        .DEPTH (WS_MAX)
    ) u_space_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (x),
        .rd_addr (rel_idx_next),
        .rd_data (rd_data)
    );

    assign x    = (w_pos_reg == 2'd0) ? w_v0_reg : w_v1_reg;
    assign x_ok = w_valid_reg && (w_pos_reg < w_n_reg);

    // Advance the run, space and punctuation stages by one step
    always_comb
    begin
        run_char_next    = run_char_reg;
        run_count_next   = run_count_reg;
        prev_cjk_next    = prev_cjk_reg;
        space_count_next = space_count_reg;
        punct_char_next  = punct_char_reg;
        punct_count_next = punct_count_reg;
        body_next        = body_reg;
        f_left_next      = f_left_reg;
        rel_active_next  = rel_active_reg;
        rel_idx_next     = rel_idx_reg;
        y3_pend_next     = y3_pend_reg;
        y3_next          = y3_reg;
        w_pos_next       = w_pos_reg;
        w_last_next      = w_last_reg;
        emit             = 1'b0;
        e_cp             = '0;
        e_has            = 1'b1;
        e_eom            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        pr               = '0;
        cur_left         = (f_left_reg != 2'd0) ? f_left_reg
                           : dtfc_pkg::run_copies(run_count_reg, run_char_reg);
        flush_now        = (f_left_reg != 2'd0) ||
                           ((run_count_reg != 2'd0) &&
                            (x_ok ? !(dtfc_pkg::is_cjk(x) && (x == run_char_reg))
                                  : w_last_reg));
        if (w_valid_reg && adv) begin
            if (rel_active_reg) begin
                // release one held space
                emit            = 1'b1;
                e_cp            = rd_data;
                punct_char_next = '0;
                punct_count_next = 2'd0;
                rel_idx_next    = rel_idx_reg + 1'b1;
                if ((CW'(rel_idx_reg) + 1'b1) == space_count_reg) begin
                    rel_active_next  = 1'b0;
                    space_count_next = '0;
                end
            end else if (y3_pend_reg) begin
                // character that followed a released space run
                pr               = dtfc_pkg::punct_step(y3_reg, punct_char_reg,
                                                        punct_count_reg, body_reg);
                punct_char_next  = pr.pchar;
                punct_count_next = pr.pcount;
                body_next        = pr.body;
                emit             = pr.emit;
                e_cp             = y3_reg;
                y3_pend_next     = 1'b0;
            end else if (flush_now) begin
                // send one copy of the ended CJK run
                emit             = 1'b1;
                e_cp             = run_char_reg;
                punct_char_next  = '0;
                punct_count_next = 2'd0;
                body_next        = 1'b1;
                space_count_next = '0;
                prev_cjk_next    = 1'b1;
                if (cur_left == 2'd1) begin
                    f_left_next    = 2'd0;
                    run_count_next = 2'd0;
                    run_char_next  = '0;
                    if (x_ok && dtfc_pkg::is_cjk(x)) begin
                        run_char_next  = x;
                        run_count_next = 2'd1;
                        w_pos_next     = w_pos_reg + 2'd1;
                    end
                end else begin
                    f_left_next = cur_left - 2'd1;
                end
            end else if (x_ok) begin
                w_pos_next = w_pos_reg + 2'd1;
                if (dtfc_pkg::is_cjk(x)) begin
                    // extend or open a run
                    run_char_next = x;
                    if (run_count_reg == 2'd0)
                        run_count_next = 2'd1;
                    else if (run_count_reg != 2'd3)
                        run_count_next = run_count_reg + 2'd1;
                end else if (dtfc_pkg::is_space(x) &&
                             ((space_count_reg != '0) || prev_cjk_reg) &&
                             (space_count_reg < CW'(WS_MAX))) begin
                    // hold a space after a CJK character
                    wr_en            = 1'b1;
                    wr_addr          = space_count_reg[AW-1:0];
                    space_count_next = space_count_reg + 1'b1;
                end else if (space_count_reg != '0) begin
                    // release held spaces, then this character
                    rel_active_next = 1'b1;
                    rel_idx_next    = '0;
                    y3_pend_next    = 1'b1;
                    y3_next         = x;
                    prev_cjk_next   = 1'b0;
                end else begin
                    pr               = dtfc_pkg::punct_step(x, punct_char_reg,
                                                            punct_count_reg, body_reg);
                    punct_char_next  = pr.pchar;
                    punct_count_next = pr.pcount;
                    body_next        = pr.body;
                    emit             = pr.emit;
                    e_cp             = x;
                    prev_cjk_next    = 1'b0;
                end
            end else if (w_last_reg) begin
                if (space_count_reg != '0) begin
                    // release trailing spaces
                    rel_active_next = 1'b1;
                    rel_idx_next    = '0;
                end else begin
                    // end marker, then back to reset state
                    emit             = 1'b1;
                    e_cp             = '0;
                    e_has            = 1'b0;
                    e_eom            = 1'b1;
                    w_last_next      = 1'b0;
                    run_char_next    = '0;
                    run_count_next   = 2'd0;
                    prev_cjk_next    = 1'b0;
                    punct_char_next  = '0;
                    punct_count_next = 2'd0;
                    body_next        = 1'b0;
                end
            end
        end
    end

    assign remaining = (w_pos_next < w_n_reg) || (f_left_next != 2'd0) ||
                       rel_active_next || y3_pend_next || w_last_next;
    assign work_done = w_valid_reg && adv && !remaining;
    assign s_axis_tready = !w_valid_reg || work_done;

    // Load a new word or retire the finished one
    always_comb
    begin
        w_valid_next = w_valid_reg;
        w_v0_next    = w_v0_reg;
        w_v1_next    = w_v1_reg;
        w_n_next     = w_n_reg;
        if (accept) begin
            w_valid_next = (lead.n != 2'd0) || lead.last;
            w_v0_next    = lead.v0;
            w_v1_next    = lead.v1;
            w_n_next     = lead.n;
        end else if (work_done) begin
            w_valid_next = 1'b0;
        end
    end

    // Fill the result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_cp_next    = out_cp_reg;
        out_has_next   = out_has_reg;
        out_eom_next   = out_eom_reg;
        if (adv) begin
            out_valid_next = emit;
            out_cp_next    = e_cp;
            out_has_next   = e_has;
            out_eom_next   = e_eom;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            w_valid_reg     <= 1'b0;
            w_n_reg         <= 2'd0;
            w_pos_reg       <= 2'd0;
            w_last_reg      <= 1'b0;
            run_char_reg    <= '0;
            run_count_reg   <= 2'd0;
            prev_cjk_reg    <= 1'b0;
            space_count_reg <= '0;
            punct_char_reg  <= '0;
            punct_count_reg <= 2'd0;
            body_reg        <= 1'b0;
            f_left_reg      <= 2'd0;
            rel_active_reg  <= 1'b0;
            rel_idx_reg     <= '0;
            y3_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            w_valid_reg     <= w_valid_next;
            w_n_reg         <= w_n_next;
            w_pos_reg       <= accept ? 2'd0 : w_pos_next;
            w_last_reg      <= accept ? lead.last : w_last_next;
            run_char_reg    <= run_char_next;
            run_count_reg   <= run_count_next;
            prev_cjk_reg    <= prev_cjk_next;
            space_count_reg <= space_count_next;
            punct_char_reg  <= punct_char_next;
            punct_count_reg <= punct_count_next;
            body_reg        <= body_next;
            f_left_reg      <= f_left_next;
            rel_active_reg  <= rel_active_next;
            rel_idx_reg     <= rel_idx_next;
            y3_pend_reg     <= y3_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        w_v0_reg    <= w_v0_next;
        w_v1_reg    <= w_v1_next;
        y3_reg      <= y3_next;
        out_cp_reg  <= out_cp_next;
        out_has_reg <= out_has_next;
        out_eom_reg <= out_eom_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_cp_reg};
    assign m_axis_tuser  = out_has_reg;
    assign m_axis_tlast  = out_eom_reg;

    a_rel_has_spaces: assert property (@(posedge clk) disable iff (!rst_n)
        rel_active_reg |-> (space_count_reg != '0))
        else $error("space release with no held spaces");

    a_flush_has_run: assert property (@(posedge clk) disable iff (!rst_n)
        (f_left_reg != 2'd0) |-> (run_count_reg != 2'd0))
        else $error("run flush with no held run");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !w_valid_reg |-> ((f_left_reg == 2'd0) && !rel_active_reg && !y3_pend_reg))
        else $error("pending work with no word loaded");

endmodule

`default_nettype wire
